// ----- rtl/mlh_pkg.sv -----
// Shared types and constants for the median LBP histogram block.
package mlh_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned X_W    = 10;
  localparam int unsigned Y_W    = 12;
  localparam int unsigned CNT_W  = 22;
  localparam int unsigned BIN_W  = 8;
  localparam int unsigned BINS   = 256;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned DIM_W  = 13;

  localparam logic [CNT_W-1:0] BIN_MAX    = '1;
  localparam logic [DIM_W-1:0] HEIGHT_MAX = 13'd4096;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic {
    KIND_CODE  = 1'b0,
    KIND_COUNT = 1'b1
  } kind_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    op_e              operation;
    logic [PIX_W-1:0] pixel;
    logic [BIN_W-1:0] bin_index;
  } in_t;

  typedef struct packed {
    kind_e             result_kind;
    logic [CODE_W-1:0] lbp_code;
    logic [X_W-1:0]    code_x;
    logic [Y_W-1:0]    code_y;
    logic              frame_last;
    logic [CNT_W-1:0]  bin_count;
  } out_t;

  // per-beat sideband that rides along the pipeline
  typedef struct packed {
    op_e              op;
    logic             emit;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic             last;
    logic [BIN_W-1:0] bin_index;
  } meta_t;

endpackage

// ----- rtl/mlh_line_buf.sv -----
// Line store memory with write-back forwarding and the dilated window registers.
module mlh_line_buf #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_SCALE = 3,
  parameter int unsigned AW        = 10,
  parameter int unsigned SW        = 2,
  parameter int unsigned SPW       = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic                          push_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [SPW-1:0]                slot_i,
  input  mlh_pkg::pix_t                 pixel_i,
  input  mlh_pkg::meta_t                meta_i,
  input  logic [SW-1:0]                 scale_i,
  input  logic [SPW-1:0]                span_i,
  output logic                          vld_o,
  output mlh_pkg::meta_t                meta_o,
  output logic [8:0][mlh_pkg::PIX_W-1:0] nb_o
);
  import mlh_pkg::*;

  localparam int unsigned LR  = 2 * MAX_SCALE;
  localparam int unsigned WIN = LR + 1;
  localparam int unsigned LRB = $clog2(LR);
  localparam int unsigned CB  = $clog2(WIN);

  logic [LR-1:0][PIX_W-1:0] mem [MAX_WIDTH];
  logic [LR-1:0][PIX_W-1:0] rd_q;

  logic                     s1_vld_q;
  logic                     s1_push_q;
  logic [AW-1:0]            s1_addr_q;
  logic [SPW-1:0]           s1_slot_q;
  pix_t                     s1_pix_q;
  meta_t                    s1_meta_q;

  logic                     lw_vld_q;
  logic [AW-1:0]            lw_addr_q;
  logic [LR-1:0][PIX_W-1:0] lw_word_q;

  logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_q;  // [column, oldest first][row]
  logic                     s2_vld_q;
  meta_t                    s2_meta_q;

  logic [LR-1:0][PIX_W-1:0] word;
  logic [LR-1:0][PIX_W-1:0] wr_word;
  logic [WIN-1:0][PIX_W-1:0] col_new;
  logic                     wr_en;
  logic [SPW:0]             sum;
  logic [CB-1:0]            cl, cm, cr, rs, rsp;

  assign wr_en = en_i && s1_vld_q && s1_push_q;

  // read-modify-write of one column word; last write forwarded on an address match
  always_comb begin
    word = (lw_vld_q && (lw_addr_q == s1_addr_q)) ? lw_word_q : rd_q;
    wr_word = word;
    wr_word[LRB'(s1_slot_q)] = s1_pix_q;
    col_new = '0;
    sum = '0;
    for (int j = 0; j < WIN; j++) begin
      if (j < LR) begin
        sum = (SPW+1)'(s1_slot_q) + (SPW+1)'(j);
        if (sum >= (SPW+1)'(span_i)) begin
          sum = sum - (SPW+1)'(span_i);
        end
      end
      if (j < int'(span_i)) begin
        col_new[j] = word[LRB'(sum)];
      end else if (j == int'(span_i)) begin
        col_new[j] = s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && vld_i && push_i) begin
      rd_q <= mem[addr_i];
    end
    if (wr_en) begin
      mem[s1_addr_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      lw_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      if (wr_en) begin
        lw_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_push_q <= push_i;
      s1_addr_q <= addr_i;
      s1_slot_q <= slot_i;
      s1_pix_q  <= pixel_i;
      s1_meta_q <= meta_i;
      s2_meta_q <= s1_meta_q;
      if (wr_en) begin
        lw_addr_q <= s1_addr_q;
        lw_word_q <= wr_word;
        for (int k = 0; k < WIN - 1; k++) begin
          win_q[k] <= win_q[k+1];
        end
        win_q[WIN-1] <= col_new;
      end
    end
  end

  // window taps: left, middle and right columns at rows 0, scale and span
  always_comb begin
    cr  = CB'(WIN - 1);
    cl  = cr - CB'(span_i);
    cm  = cr - CB'(scale_i);
    rs  = CB'(scale_i);
    rsp = CB'(span_i);
    nb_o[0] = win_q[cl][0];
    nb_o[1] = win_q[cm][0];
    nb_o[2] = win_q[cr][0];
    nb_o[3] = win_q[cr][rs];
    nb_o[4] = win_q[cr][rsp];
    nb_o[5] = win_q[cm][rsp];
    nb_o[6] = win_q[cl][rsp];
    nb_o[7] = win_q[cl][rs];
    nb_o[8] = win_q[cm][rs];
  end

  assign vld_o  = s2_vld_q;
  assign meta_o = s2_meta_q;

endmodule

// ----- rtl/mlh_median.sv -----
// Three-stage median of nine and neighbor comparison into the pattern code.
module mlh_median (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  mlh_pkg::meta_t                 meta_i,
  input  logic [8:0][mlh_pkg::PIX_W-1:0] nb_i,
  output logic                           vld_o,
  output mlh_pkg::meta_t                 meta_o,
  output logic [mlh_pkg::CODE_W-1:0]     code_o
);
  import mlh_pkg::*;

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // stage A: each column sorted into low / mid / high
  logic                       a_vld_q, b_vld_q;
  meta_t                      a_meta_q, b_meta_q, c_meta_q;
  logic [7:0][PIX_W-1:0]      a_nb_q, b_nb_q;
  logic [2:0][PIX_W-1:0]      a_lo_q, a_mid_q, a_hi_q;
  pix_t                       b_lo_q, b_mid_q, b_hi_q;
  logic                       c_vld_q;
  logic [CODE_W-1:0]          c_code_q;

  logic [2:0][2:0][PIX_W-1:0] trip;
  pix_t                       med;
  logic [CODE_W-1:0]          code;

  always_comb begin
    trip[0] = {nb_i[6], nb_i[7], nb_i[0]};
    trip[1] = {nb_i[5], nb_i[8], nb_i[1]};
    trip[2] = {nb_i[4], nb_i[3], nb_i[2]};
    med = med3(b_lo_q, b_mid_q, b_hi_q);
    for (int k = 0; k < CODE_W; k++) begin
      code[k] = (med <= b_nb_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_meta_q <= meta_i;
      a_nb_q   <= nb_i[7:0];
      for (int i = 0; i < 3; i++) begin
        a_lo_q[i]  <= min2(min2(trip[i][0], trip[i][1]), trip[i][2]);
        a_hi_q[i]  <= max2(max2(trip[i][0], trip[i][1]), trip[i][2]);
        a_mid_q[i] <= med3(trip[i][0], trip[i][1], trip[i][2]);
      end
      b_meta_q <= a_meta_q;
      b_nb_q   <= a_nb_q;
      b_lo_q   <= max2(max2(a_lo_q[0], a_lo_q[1]), a_lo_q[2]);
      b_mid_q  <= med3(a_mid_q[0], a_mid_q[1], a_mid_q[2]);
      b_hi_q   <= min2(min2(a_hi_q[0], a_hi_q[1]), a_hi_q[2]);
      c_meta_q <= b_meta_q;
      c_code_q <= code;
    end
  end

  assign vld_o  = c_vld_q;
  assign meta_o = c_meta_q;
  assign code_o = c_code_q;

endmodule

// ----- rtl/mlh_hist.sv -----
// Histogram memory: saturating increment and read-and-clear with forwarding.
module mlh_hist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  mlh_pkg::meta_t             meta_i,
  input  logic [mlh_pkg::CODE_W-1:0] code_i,
  output logic                       res_vld_o,
  output mlh_pkg::out_t              res_o
);
  import mlh_pkg::*;

  logic [CNT_W-1:0] mem [BINS];
  logic [CNT_W-1:0] rd_q;
  logic [BINS-1:0]  hv_q;      // bin written since reset
  logic             hv_rd_q;

  logic             s6_vld_q;
  meta_t            s6_meta_q;
  logic [BIN_W-1:0] s6_addr_q;
  logic [CODE_W-1:0] s6_code_q;

  logic             lw_vld_q;
  logic [BIN_W-1:0] lw_addr_q;
  logic [CNT_W-1:0] lw_cnt_q;

  logic             use_in;
  logic [BIN_W-1:0] addr_in;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] wdata;
  logic             we;

  always_comb begin
    use_in  = vld_i && ((meta_i.op == OP_READ) || meta_i.emit);
    addr_in = (meta_i.op == OP_READ) ? meta_i.bin_index : code_i;
    if (lw_vld_q && (lw_addr_q == s6_addr_q)) begin
      cur = lw_cnt_q;
    end else if (hv_rd_q) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
    if (s6_meta_q.op == OP_READ) begin
      wdata = '0;
    end else begin
      wdata = (cur == BIN_MAX) ? cur : cur + 1'b1;
    end
    we = en_i && s6_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i && use_in) begin
      rd_q    <= mem[addr_in];
      hv_rd_q <= hv_q[addr_in];
    end
    if (we) begin
      mem[s6_addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
      lw_vld_q <= 1'b0;
      hv_q     <= '0;
    end else if (en_i) begin
      s6_vld_q <= use_in;
      if (we) begin
        lw_vld_q        <= 1'b1;
        hv_q[s6_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_meta_q <= meta_i;
      s6_addr_q <= addr_in;
      s6_code_q <= code_i;
      if (we) begin
        lw_addr_q <= s6_addr_q;
        lw_cnt_q  <= wdata;
      end
    end
  end

  always_comb begin
    res_vld_o = s6_vld_q;
    res_o     = '0;
    if (s6_meta_q.op == OP_READ) begin
      res_o.result_kind = KIND_COUNT;
      res_o.bin_count   = cur;
    end else begin
      res_o.result_kind = KIND_CODE;
      res_o.lbp_code    = s6_code_q;
      res_o.code_x      = s6_meta_q.x;
      res_o.code_y      = s6_meta_q.y;
      res_o.frame_last  = s6_meta_q.last;
    end
  end

endmodule

// ----- rtl/median_lbp_histogram_top.sv -----
// Top level of the median LBP histogram block: counters, config, pipeline and output skid.
//
// Takes one beat per clock: a pixel push or a histogram bin read-and-clear.
// A push that completes a dilated 3x3 window (spacing = scale) yields an 8-bit
// median LBP code with its reduced-image coordinates and bumps the matching
// histogram bin (saturating at 2^22-1); a bin read returns and clears the bin.
// Sustained rate is one beat per cycle while the output skid stage is empty; a
// result passes the line-store read, window update, three median stages,
// histogram read, and histogram write-back into the output register, in that
// order. The line store is one memory of MAX_WIDTH words, each holding one
// column of the last 2*MAX_SCALE rows, read and written back once per push;
// the histogram is one 256-entry memory read and written back once per bin
// read or code-yielding push, both with forwarding of the last write. No
// clearing pass: bins carry reset-cleared valid flags. A write to a mapped
// config register restarts the frame counters and keeps the histogram; write
// config only while the block is idle. Input ready drops only while the output
// skid stage is full.
module median_lbp_histogram_top #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_SCALE = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mlh_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mlh_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [mlh_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [mlh_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import mlh_pkg::*;

  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SW  = $clog2(MAX_SCALE + 1);
  localparam int unsigned SPW = $clog2(2 * MAX_SCALE + 1);

  // config registers
  logic [1:0]       scale_q;
  logic [10:0]      width_q;
  logic [12:0]      height_q;

  // frame position
  logic [AW-1:0]    col_q, col_d;
  logic [Y_W-1:0]   row_q, row_d;
  logic [SPW-1:0]   slot_q, slot_d;   // row modulo span

  logic [SW-1:0]    s_eff;
  logic [SPW-1:0]   span;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [AW-1:0]    c0;
  logic [Y_W-1:0]   r0;
  logic [SPW-1:0]   slot0;
  logic             col_end, row_end, row_over, emit;
  logic [DIM_W-1:0] dx, dy;

  logic             acc, push, en;
  meta_t            meta_s0;

  logic             lb_vld, md_vld, res_vld;
  meta_t            lb_meta, md_meta;
  logic [8:0][PIX_W-1:0] nb;
  logic [CODE_W-1:0] code;
  out_t             res;

  // output register plus one skid entry
  logic             ov_q, sk_q;
  out_t             out_q, skd_q;
  logic             take;

  assign en         = !sk_q;
  assign in_ready_o = !sk_q;
  assign acc        = in_valid_i && in_ready_o;
  assign push       = (in_data_i.operation == OP_PUSH);

  // out-of-range settings clamp
  always_comb begin
    if (scale_q == 2'd0) begin
      s_eff = SW'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_q);
    end
    span = SPW'({s_eff, 1'b0});
    if (width_q == 11'd0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(width_q);
    end
    if (height_q == 13'd0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = height_q;
    end
  end

  // position of this push and the next one
  always_comb begin
    row_over = (DIM_W'(row_q) >= h_eff);
    c0       = (DIM_W'(col_q) >= w_eff) ? '0 : col_q;
    r0       = row_over ? '0 : row_q;
    slot0    = row_over ? '0 : slot_q;
    col_end  = (DIM_W'(c0) + 1'b1 >= w_eff);
    row_end  = (DIM_W'(r0) + 1'b1 >= h_eff);
    emit     = (DIM_W'(c0) >= DIM_W'(span)) && (DIM_W'(r0) >= DIM_W'(span));
    dx       = DIM_W'(c0) - DIM_W'(span);
    dy       = DIM_W'(r0) - DIM_W'(span);
    col_d    = c0;
    row_d    = r0;
    slot_d   = slot0;
    if (col_end) begin
      col_d = '0;
      if (row_end) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = r0 + 1'b1;
        slot_d = (slot0 + 1'b1 == span) ? '0 : slot0 + 1'b1;
      end
    end else begin
      col_d = c0 + 1'b1;
    end

    meta_s0           = '0;
    meta_s0.op        = in_data_i.operation;
    meta_s0.emit      = push && emit;
    meta_s0.x         = X_W'(dx);
    meta_s0.y         = Y_W'(dy);
    meta_s0.last      = col_end && row_end;
    meta_s0.bin_index = in_data_i.bin_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 2'd1;
      width_q  <= 11'd512;
      height_q <= 13'd512;
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
    end else if (cfg_we_i && (cfg_idx_i == REG_SCALE || cfg_idx_i == REG_WIDTH ||
                              cfg_idx_i == REG_HEIGHT)) begin
      unique case (cfg_idx_i)
        REG_SCALE:  scale_q  <= cfg_wdata_i[1:0];
        REG_WIDTH:  width_q  <= cfg_wdata_i[10:0];
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default:    ;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (acc && push) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  mlh_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .AW        (AW),
    .SW        (SW),
    .SPW       (SPW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (acc),
    .push_i  (push),
    .addr_i  (c0),
    .slot_i  (slot0),
    .pixel_i (in_data_i.pixel),
    .meta_i  (meta_s0),
    .scale_i (s_eff),
    .span_i  (span),
    .vld_o   (lb_vld),
    .meta_o  (lb_meta),
    .nb_o    (nb)
  );

  mlh_median u_median (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (lb_vld),
    .meta_i (lb_meta),
    .nb_i   (nb),
    .vld_o  (md_vld),
    .meta_o (md_meta),
    .code_o (code)
  );

  mlh_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (md_vld),
    .meta_i    (md_meta),
    .code_i    (code),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // output stage: result goes to the output register, or to skid if it is stuck
  assign take = ov_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sk_q <= 1'b0;
    end else if (sk_q) begin
      if (take) begin
        sk_q <= 1'b0;
      end
    end else if (!ov_q || take) begin
      ov_q <= res_vld;
    end else if (res_vld) begin
      sk_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_q) begin
      if (take) begin
        out_q <= skd_q;
      end
    end else if (!ov_q || take) begin
      if (res_vld) begin
        out_q <= res;
      end
    end else if (res_vld) begin
      skd_q <= res;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  // skid entry is only ever used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_q |-> ov_q)
    else $error("skid entry full with empty output register");

  // a code beat never carries a count, a count beat never carries a code
  a_code_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_kind == KIND_CODE) |-> out_data_o.bin_count == '0)
    else $error("code result with nonzero bin count");

  a_count_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_kind == KIND_COUNT) |->
      (out_data_o.lbp_code == '0 && out_data_o.frame_last == 1'b0))
    else $error("count result with code fields set");

  // the column counter stays inside the line store
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && push) |=> (32'(col_q) < MAX_WIDTH))
    else $error("column counter beyond line store depth");

endmodule

// ----- sim/median_lbp_checker.sv -----
// Checker for the median LBP histogram block: predicts every result beat and compares it.
module median_lbp_checker
  import mlh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o,
  output int unsigned           codes_o,
  output int unsigned           counts_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_W = 1024;
  localparam int unsigned WIN_N  = 7;

  logic [1:0]        scale_q;
  logic [10:0]       width_q;
  logic [12:0]       height_q;
  logic [PIX_W-1:0]  line_mem [6*LINE_W];
  logic [PIX_W-1:0]  win_q [WIN_N][WIN_N];  // [column, oldest first][row, top first]
  int unsigned       col_q, row_q;
  logic [CNT_W-1:0]  hist_q [BINS];
  out_t              expected_beats [$];

  assign pending_o = expected_beats.size();

  function automatic logic [PIX_W-1:0] median_of(input logic [PIX_W-1:0] v [9]);
    int unsigned lt, le;
    for (int i = 0; i < 9; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) lt++;
        if (v[j] <= v[i]) le++;
      end
      if (lt <= 4 && le >= 5) return v[i];
    end
    return v[0];
  endfunction

  task automatic predict_beat(input in_t beat);
    int unsigned s, span, w, h, c, r, cl, cm;
    logic [PIX_W-1:0] nb [9];
    logic [PIX_W-1:0] med;
    logic [CODE_W-1:0] code;
    out_t res;
    res = '0;
    if (beat.operation == OP_READ) begin
      res.result_kind = KIND_COUNT;
      res.bin_count   = hist_q[beat.bin_index];
      hist_q[beat.bin_index] = '0;
      expected_beats = {expected_beats, res};
      return;
    end
    s = (scale_q == 0) ? 1 : scale_q;
    span = 2 * s;
    w = (width_q == 0) ? 1 : ((width_q > LINE_W) ? LINE_W : width_q);
    h = (height_q == 0) ? 1 : ((height_q > 4096) ? 4096 : height_q);
    c = (col_q >= w) ? 0 : col_q;
    r = (row_q >= h) ? 0 : row_q;
    // column shift register takes the stored rows above plus the new pixel
    for (int k = 0; k < WIN_N - 1; k++) win_q[k] = win_q[k+1];
    for (int j = 0; j < WIN_N; j++) win_q[WIN_N-1][j] = '0;
    for (int j = 0; j < span; j++) win_q[WIN_N-1][j] = line_mem[((r + j) % span) * LINE_W + c];
    win_q[WIN_N-1][span] = beat.pixel;
    line_mem[(r % span) * LINE_W + c] = beat.pixel;
    if (c >= span && r >= span) begin
      cl = WIN_N - 1 - span;
      cm = WIN_N - 1 - s;
      nb[0] = win_q[cl][0];
      nb[1] = win_q[cm][0];
      nb[2] = win_q[WIN_N-1][0];
      nb[3] = win_q[WIN_N-1][s];
      nb[4] = win_q[WIN_N-1][span];
      nb[5] = win_q[cm][span];
      nb[6] = win_q[cl][span];
      nb[7] = win_q[cl][s];
      nb[8] = win_q[cm][s];
      med = median_of(nb);
      code = '0;
      for (int k = 0; k < 8; k++) if (med <= nb[k]) code[k] = 1'b1;
      if (hist_q[code] != BIN_MAX) hist_q[code] = hist_q[code] + 1'b1;
      res.result_kind = KIND_CODE;
      res.lbp_code    = code;
      res.code_x      = X_W'(c - span);
      res.code_y      = Y_W'(r - span);
      res.frame_last  = (c + 1 == w && r + 1 == h);
      expected_beats = {expected_beats, res};
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_q = c;
    row_q = r;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_b;
    if (!rst_ni) begin
      scale_q  = 2'd1;
      width_q  = 11'd512;
      height_q = 13'd512;
      col_q = 0;
      row_q = 0;
      for (int i = 0; i < 6*LINE_W; i++) line_mem[i] = '0;
      for (int k = 0; k < WIN_N; k++) for (int j = 0; j < WIN_N; j++) win_q[k][j] = '0;
      for (int i = 0; i < BINS; i++) hist_q[i] = '0;
      expected_beats.delete();
      errors_o = 0;
      codes_o  = 0;
      counts_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCALE:  begin scale_q  = cfg_wdata_i[1:0];  col_q = 0; row_q = 0; end
          REG_WIDTH:  begin width_q  = cfg_wdata_i[10:0]; col_q = 0; row_q = 0; end
          REG_HEIGHT: begin height_q = cfg_wdata_i[12:0]; col_q = 0; row_q = 0; end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data_i);
          errors_o++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (exp_b.result_kind == KIND_CODE) codes_o++; else counts_o++;
          check_field("result_kind", exp_b.result_kind, out_data_i.result_kind);
          check_field("lbp_code", exp_b.lbp_code, out_data_i.lbp_code);
          check_field("code_x", exp_b.code_x, out_data_i.code_x);
          check_field("code_y", exp_b.code_y, out_data_i.code_y);
          check_field("frame_last", exp_b.frame_last, out_data_i.frame_last);
          check_field("bin_count", exp_b.bin_count, out_data_i.bin_count);
        end
      end
      if (in_valid_i && in_ready_i) predict_beat(in_data_i);
    end
  end

endmodule

// ----- sim/median_lbp_histogram_top_test.sv -----
// Testbench top for the median LBP histogram block: stimulus, flow control and verdict.
module median_lbp_histogram_top_test;
  import mlh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_t              in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  int unsigned pending, errors, codes, counts;
  int unsigned send_idle_pct = 0;   // chance per cycle that the sender sits idle
  int unsigned recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int unsigned hold_req = 0;        // bumped by stimulus to ask for a long hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned pushes = 0, reads = 0, phases = 0;

  always #5 clk_i = ~clk_i;

  median_lbp_histogram_top dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  median_lbp_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pending_o(pending), .errors_o(errors), .codes_o(codes), .counts_o(counts)
  );

  // Receiver: random stalls, plus a long hold-off on request so the output
  // skid fills and in_ready drops while the sender keeps offering beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one beat and hold it until accepted. Valid stays high after the
  // beat unless the sender decides to idle, so back-to-back beats never dip.
  task automatic send_beat(input op_e op, input pix_t pix, input logic [BIN_W-1:0] bin);
    in_valid_i <= 1'b1;
    in_data_i  <= '{operation: op, pixel: pix, bin_index: bin};
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_PUSH) pushes++; else reads++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Let every expected beat come back, then let the pipeline empty,
  // since a push that yields nothing may still be in flight.
  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(input int unsigned sc, input int unsigned w, input int unsigned h);
    write_reg(REG_SCALE, sc);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // mode 0: no idling, 1: sender idle 80%, 2: receiver stalls 80%, 3: both 14%
  task automatic run_phase(input int unsigned sc, input int unsigned w, input int unsigned h,
                           input int unsigned n, input int unsigned mode, input bit squeeze);
    pix_t pix;
    setup(sc, w, h);
    phases++;
    send_idle_pct  = (mode == 1) ? 80 : (mode == 3) ? 14 : 0;
    recv_stall_pct = (mode == 2) ? 80 : (mode == 3) ? 14 : 0;
    if (squeeze) hold_req++;
    for (int unsigned i = 0; i < n; i++) begin
      // a narrow band of grey levels gives plenty of ties around the median
      pix = ($urandom_range(99) < 30) ? pix_t'($urandom_range(136, 120)) : pix_t'($urandom);
      if ($urandom_range(99) < 12) send_beat(OP_READ, pix, BIN_W'($urandom));
      else send_beat(OP_PUSH, pix, BIN_W'($urandom));
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    pix_t alt [9];
    alt = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3x3 frames give exactly one code each, flagged as frame end
    setup(1, 3, 3);
    for (int i = 0; i < 9; i++) send_beat(OP_PUSH, 8'd255, 8'd0);  // flat frame, all bits set
    for (int i = 0; i < 9; i++) send_beat(OP_PUSH, alt[i], 8'hFF);  // edge-only bits
    send_beat(OP_READ, 8'hFF, 8'hFF);
    send_beat(OP_READ, 8'h00, 8'hAA);
    send_beat(OP_READ, 8'h00, 8'hAA);  // just cleared
    send_beat(OP_READ, 8'h00, 8'h00);
    write_reg(REG_SCALE, 0);           // zero scale behaves as one
    write_reg(3, 8191);                // unmapped index, must be ignored
    for (int i = 0; i < 9; i++) send_beat(OP_PUSH, $urandom_range(1) ? 8'd255 : 8'd0, 8'd0);

    // random phases across scales, frame sizes and flow-control patterns
    run_phase(1, 7, 7, 200, 0, 0);
    run_phase(2, 9, 8, 200, 1, 0);
    run_phase(3, 7, 7, 200, 2, 1);     // long output hold-off backs up the input
    run_phase(3, 13, 9, 200, 3, 0);
    run_phase(3, 6, 6, 40, 0, 0);      // frame too small for a window
    run_phase(2, 0, 9, 30, 3, 0);      // zero width behaves as one
    run_phase(1, 7, 0, 30, 3, 0);      // zero height behaves as one
    run_phase(2, 8, 8191, 120, 2, 0);  // height clamps to the maximum
    run_phase(1, 2047, 7, 400, 3, 0);  // width clamps to 1024
    run_phase(2, 7, 7, 100, 1, 0);
    run_phase(3, 1024, 7, 100, 0, 0);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d pushes and %0d bin reads over %0d random phases plus directed frames.",
             pushes, reads, phases);
    $display("Checked %0d code beats and %0d bin count beats.", codes, counts);
    if (errors == 0) begin
      $display("median_lbp_histogram_top test passed");
    end else begin
      $display("median_lbp_histogram_top test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("median_lbp_histogram_top test failed");
    $finish;
  end

endmodule
